[sv/vmdf_pkg.sv]
// ----------------------------------------------------------------------------
// vmdf_pkg
// Shared widths, types and helpers of the voxel max difference finder.
// ----------------------------------------------------------------------------
package vmdf_pkg;

    localparam int DIM_MAX     = 4096;
    localparam int FRAME_MAX   = 1024;
    localparam int SAMPLE_BITS = 32;

    localparam int DIM_W  = 13;                  // columns, rows, planes, x/y/z outputs
    localparam int FRM_W  = 11;                  // frames, t output
    localparam int CNT_W  = $clog2(DIM_MAX);     // running x/y/z counter
    localparam int FCNT_W = $clog2(FRAME_MAX);   // running frame counter
    localparam int MAG_W  = SAMPLE_BITS + 1;     // |a-b| and |a+b|
    localparam int RES_W  = 32;                  // Q16.16 result width

    localparam int ADDR_W = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_PLANES  = 2'd2;
    localparam logic [1:0] REG_FRAMES  = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] columns;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] planes;
        logic [FRM_W-1:0] frames;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  x;
        logic [CNT_W-1:0]  y;
        logic [CNT_W-1:0]  z;
        logic [FCNT_W-1:0] t;
    } t_pos;

    // classified pair, queued between front and back
    typedef struct packed {
        logic [MAG_W-1:0] diff;
        logic [MAG_W-1:0] sum;
        t_pos             pos;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [RES_W-1:0] abs_max;
        logic [DIM_W-1:0] abs_x;
        logic [DIM_W-1:0] abs_y;
        logic [DIM_W-1:0] abs_z;
        logic [FRM_W-1:0] abs_t;
        logic [RES_W-1:0] rel_max;
        logic [DIM_W-1:0] rel_x;
        logic [DIM_W-1:0] rel_y;
        logic [DIM_W-1:0] rel_z;
        logic [FRM_W-1:0] rel_t;
        logic             rel_unbounded;
        logic             any_difference;
    } t_result;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] f_eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(DIM_MAX)) begin
            r = DIM_W'(DIM_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [FRM_W-1:0] f_eff_frames(input logic [FRM_W-1:0] v);
        logic [FRM_W-1:0] r;
        if (v == '0) begin
            r = FRM_W'(1);
        end else if (v > FRM_W'(FRAME_MAX)) begin
            r = FRM_W'(FRAME_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/vmdf_front.sv]
// ----------------------------------------------------------------------------
// vmdf_front
// Accepts sample pairs, forms |a-b| and |a+b|, tags each item with its
// voxel position and an end-of-image flag, and pushes it into the queue.
// ----------------------------------------------------------------------------
module vmdf_front
    import vmdf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_a,
    input  logic [SAMPLE_BITS-1:0] i_sample_b,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_item                  o_item
);

    logic [CNT_W-1:0]  r_col,   n_col;
    logic [CNT_W-1:0]  r_row,   n_row;
    logic [CNT_W-1:0]  r_plane, n_plane;
    logic [FCNT_W-1:0] r_frame, n_frame;

    logic signed [MAG_W-1:0] w_diff;
    logic signed [MAG_W-1:0] w_sum;
    logic [DIM_W-1:0]        w_eff_cols;
    logic [DIM_W-1:0]        w_eff_rows;
    logic [DIM_W-1:0]        w_eff_planes;
    logic [FRM_W-1:0]        w_eff_frames;
    logic                    w_f_wrap;
    logic                    w_c_wrap;
    logic                    w_r_wrap;
    logic                    w_p_wrap;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        w_diff = $signed({i_sample_a[SAMPLE_BITS-1], i_sample_a})
               - $signed({i_sample_b[SAMPLE_BITS-1], i_sample_b});
        w_sum  = $signed({i_sample_a[SAMPLE_BITS-1], i_sample_a})
               + $signed({i_sample_b[SAMPLE_BITS-1], i_sample_b});
    end

    always_comb begin
        w_eff_cols   = f_eff_dim(i_cfg.columns);
        w_eff_rows   = f_eff_dim(i_cfg.rows);
        w_eff_planes = f_eff_dim(i_cfg.planes);
        w_eff_frames = f_eff_frames(i_cfg.frames);

        // a counter at or past its last index wraps and carries on
        w_f_wrap = ({1'b0, r_frame} + FRM_W'(1)) >= w_eff_frames;
        w_c_wrap = w_f_wrap && (({1'b0, r_col} + DIM_W'(1)) >= w_eff_cols);
        w_r_wrap = w_c_wrap && (({1'b0, r_row} + DIM_W'(1)) >= w_eff_rows);
        w_p_wrap = w_r_wrap && (({1'b0, r_plane} + DIM_W'(1)) >= w_eff_planes);

        n_frame = w_f_wrap ? '0 : r_frame + FCNT_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        if (w_f_wrap) begin
            n_col = w_c_wrap ? '0 : r_col + CNT_W'(1);
        end
        if (w_c_wrap) begin
            n_row = w_r_wrap ? '0 : r_row + CNT_W'(1);
        end
        if (w_r_wrap) begin
            n_plane = w_p_wrap ? '0 : r_plane + CNT_W'(1);
        end
    end

    always_comb begin
        o_item.diff  = w_diff[MAG_W-1] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
        o_item.sum   = w_sum[MAG_W-1]  ? MAG_W'(-w_sum)  : MAG_W'(w_sum);
        o_item.pos.x = r_col;
        o_item.pos.y = r_row;
        o_item.pos.z = r_plane;
        o_item.pos.t = r_frame;
        o_item.last  = w_p_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
            r_frame <= '0;
        end else if (o_push) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
            r_frame <= n_frame;
        end
    end

endmodule

[sv/vmdf_queue.sv]
// ----------------------------------------------------------------------------
// vmdf_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module vmdf_queue
    import vmdf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;

    assign o_full  = r_count == (PTR_W+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

[sv/vmdf_back.sv]
// ----------------------------------------------------------------------------
// vmdf_back
// Keeps the running maxima, works out the relative difference with a
// bit-serial divider and emits the summary at the end of each image.
// ----------------------------------------------------------------------------
module vmdf_back
    import vmdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_item   i_q_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = RES_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int NUM_W     = MAG_W + 1;                 // 2*|a-b|
    localparam int WIDE_W    = MAG_W + FRAC_BITS;

    logic [1:0]        r_state;
    t_item             r_cur;

    logic [RES_W-1:0]  r_best_abs;
    t_pos              r_best_abs_pos;
    logic [RES_W-1:0]  r_best_rel;
    t_pos              r_best_rel_pos;
    logic [RES_W-1:0]  r_zs_best;

    logic [MAG_W-1:0]  r_rem;
    logic [RES_W-1:0]  r_bits;
    logic [RES_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    t_result           r_out;

    logic [RES_W-1:0]  w_d32;
    logic [NUM_W-1:0]  w_num;
    logic              w_ovf;
    logic [NUM_W-1:0]  w_rem2;
    logic              w_ge;
    logic [NUM_W-1:0]  w_rem_next;
    logic [RES_W-1:0]  w_quo_next;
    logic              w_out_free;
    logic              w_rel_valid;
    logic              w_unb;

    assign o_pop       = (r_state == ST_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_d32 = r_cur.diff[MAG_W-1] ? '1 : r_cur.diff[RES_W-1:0];
        w_num = {r_cur.diff, 1'b0};
        // integer part of 2d/s beyond 16 bits saturates the ratio
        w_ovf = {{(WIDE_W-NUM_W){1'b0}}, w_num} >= {r_cur.sum, {FRAC_BITS{1'b0}}};

        w_rem2     = {r_rem, r_bits[RES_W-1]};
        w_ge       = w_rem2 >= {1'b0, r_cur.sum};
        w_rem_next = w_ge ? (w_rem2 - {1'b0, r_cur.sum}) : w_rem2;
        w_quo_next = {r_quo[RES_W-2:0], w_ge};

        w_unb       = r_zs_best != '0;
        w_rel_valid = w_unb || (r_best_rel != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_best_abs     <= '0;
            r_best_abs_pos <= '0;
            r_best_rel     <= '0;
            r_best_rel_pos <= '0;
            r_zs_best      <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cur   <= i_q_item;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_state <= ST_FINISH;
                    if (w_d32 > r_best_abs) begin
                        r_best_abs     <= w_d32;
                        r_best_abs_pos <= r_cur.pos;
                    end
                    if (r_cur.sum == '0) begin
                        if (w_d32 > r_zs_best) begin
                            r_zs_best      <= w_d32;
                            r_best_rel_pos <= r_cur.pos;
                        end
                    end else if (r_zs_best != '0 || r_cur.diff == '0) begin
                        // ratio cannot change the relative maximum: skip it
                    end else if (w_ovf) begin
                        if (r_best_rel != '1) begin
                            r_best_rel     <= '1;
                            r_best_rel_pos <= r_cur.pos;
                        end
                    end else begin
                        // upper bits of the quotient are known zero
                        r_rem   <= MAG_W'(w_num[NUM_W-1:FRAC_BITS]);
                        r_bits  <= {w_num[FRAC_BITS-1:0], {(RES_W-FRAC_BITS){1'b0}}};
                        r_quo   <= '0;
                        r_step  <= STEP_W'(DIV_STEPS-1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= w_rem_next[MAG_W-1:0];
                    r_bits <= {r_bits[RES_W-2:0], 1'b0};
                    r_quo  <= w_quo_next;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        if (w_quo_next > r_best_rel) begin
                            r_best_rel     <= w_quo_next;
                            r_best_rel_pos <= r_cur.pos;
                        end
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!r_cur.last) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.abs_max        <= r_best_abs;
                        r_out.abs_x          <= (r_best_abs != '0) ?
                                                ({1'b0, r_best_abs_pos.x} + DIM_W'(1)) : '0;
                        r_out.abs_y          <= (r_best_abs != '0) ?
                                                ({1'b0, r_best_abs_pos.y} + DIM_W'(1)) : '0;
                        r_out.abs_z          <= (r_best_abs != '0) ?
                                                ({1'b0, r_best_abs_pos.z} + DIM_W'(1)) : '0;
                        r_out.abs_t          <= (r_best_abs != '0) ?
                                                ({1'b0, r_best_abs_pos.t} + FRM_W'(1)) : '0;
                        r_out.rel_max        <= w_unb ? '1 : r_best_rel;
                        r_out.rel_x          <= w_rel_valid ?
                                                ({1'b0, r_best_rel_pos.x} + DIM_W'(1)) : '0;
                        r_out.rel_y          <= w_rel_valid ?
                                                ({1'b0, r_best_rel_pos.y} + DIM_W'(1)) : '0;
                        r_out.rel_z          <= w_rel_valid ?
                                                ({1'b0, r_best_rel_pos.z} + DIM_W'(1)) : '0;
                        r_out.rel_t          <= w_rel_valid ?
                                                ({1'b0, r_best_rel_pos.t} + FRM_W'(1)) : '0;
                        r_out.rel_unbounded  <= w_unb;
                        r_out.any_difference <= (r_best_abs != '0) || w_rel_valid;
                        // clear the running maxima for the next image
                        r_best_abs     <= '0;
                        r_best_abs_pos <= '0;
                        r_best_rel     <= '0;
                        r_best_rel_pos <= '0;
                        r_zs_best      <= '0;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/voxel_max_difference_finder_unit.sv]
// ----------------------------------------------------------------------------
// voxel_max_difference_finder_unit
// Finds the largest absolute and relative difference of two voxel images.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_sample_a, i_sample_b
//  result    out        o_out_valid / i_out_ready o_abs_*, o_rel_*, flags
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
//  In the back end each item passes idle, check and finish, and divide for a
//  ratio: the bit-serial divider retires one quotient bit a cycle over 32 bits.
//  A four-entry queue lets the front accept items while the back divides.
//  Reset clears the position counters, the running maxima and the queue.
//  The result of the last item of an image waits in the output register.
// ----------------------------------------------------------------------------
module voxel_max_difference_finder_unit
    import vmdf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_a,
    input  logic [SAMPLE_BITS-1:0] i_sample_b,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [RES_W-1:0]       o_abs_max,
    output logic [DIM_W-1:0]       o_abs_x,
    output logic [DIM_W-1:0]       o_abs_y,
    output logic [DIM_W-1:0]       o_abs_z,
    output logic [FRM_W-1:0]       o_abs_t,
    output logic [RES_W-1:0]       o_rel_max,
    output logic [DIM_W-1:0]       o_rel_x,
    output logic [DIM_W-1:0]       o_rel_y,
    output logic [DIM_W-1:0]       o_rel_z,
    output logic [FRM_W-1:0]       o_rel_t,
    output logic                   o_rel_unbounded,
    output logic                   o_any_difference
);

    t_cfg    r_cfg;
    logic    w_push;
    logic    w_pop;
    logic    w_q_full;
    logic    w_q_empty;
    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns <= DIM_W'(1);
            r_cfg.rows    <= DIM_W'(1);
            r_cfg.planes  <= DIM_W'(1);
            r_cfg.frames  <= FRM_W'(1);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_COLUMNS: r_cfg.columns <= pwdata[DIM_W-1:0];
                REG_ROWS:    r_cfg.rows    <= pwdata[DIM_W-1:0];
                REG_PLANES:  r_cfg.planes  <= pwdata[DIM_W-1:0];
                REG_FRAMES:  r_cfg.frames  <= pwdata[FRM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COLUMNS: prdata = {{(32-DIM_W){1'b0}}, r_cfg.columns};
            REG_ROWS:    prdata = {{(32-DIM_W){1'b0}}, r_cfg.rows};
            REG_PLANES:  prdata = {{(32-DIM_W){1'b0}}, r_cfg.planes};
            REG_FRAMES:  prdata = {{(32-FRM_W){1'b0}}, r_cfg.frames};
            default:     prdata = '0;
        endcase
    end

    vmdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample_a (i_sample_a),
        .i_sample_b (i_sample_b),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    vmdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    vmdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_abs_max        = w_result.abs_max;
    assign o_abs_x          = w_result.abs_x;
    assign o_abs_y          = w_result.abs_y;
    assign o_abs_z          = w_result.abs_z;
    assign o_abs_t          = w_result.abs_t;
    assign o_rel_max        = w_result.rel_max;
    assign o_rel_x          = w_result.rel_x;
    assign o_rel_y          = w_result.rel_y;
    assign o_rel_z          = w_result.rel_z;
    assign o_rel_t          = w_result.rel_t;
    assign o_rel_unbounded  = w_result.rel_unbounded;
    assign o_any_difference = w_result.any_difference;

endmodule

[sv/vmdf_checker.sv]
// ----------------------------------------------------------------------------
// vmdf_checker
// Port-level checks of the voxel max difference finder, bound to the top.
// ----------------------------------------------------------------------------
module vmdf_checker
    import vmdf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [ADDR_W-1:0]      paddr,
    input logic [31:0]            pwdata,
    input logic [31:0]            prdata,
    input logic                   pready,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [SAMPLE_BITS-1:0] i_sample_a,
    input logic [SAMPLE_BITS-1:0] i_sample_b,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [RES_W-1:0]       o_abs_max,
    input logic [DIM_W-1:0]       o_abs_x,
    input logic [DIM_W-1:0]       o_abs_y,
    input logic [DIM_W-1:0]       o_abs_z,
    input logic [FRM_W-1:0]       o_abs_t,
    input logic [RES_W-1:0]       o_rel_max,
    input logic [DIM_W-1:0]       o_rel_x,
    input logic [DIM_W-1:0]       o_rel_y,
    input logic [DIM_W-1:0]       o_rel_z,
    input logic [FRM_W-1:0]       o_rel_t,
    input logic                   o_rel_unbounded,
    input logic                   o_any_difference
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_abs_max) && $stable(o_rel_max) && $stable(o_rel_x))
        else $error("result changed while stalled");

    a_abs_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_abs_max != '0) == (o_abs_x != '0))
                     && ((o_abs_max != '0) == (o_abs_t != '0)))
        else $error("absolute position does not match absolute maximum");

    a_unbounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rel_unbounded |-> (o_rel_max == '1) && (o_rel_x != '0))
        else $error("unbounded result without saturated ratio or position");

    a_any_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_any_difference == ((o_abs_x != '0) || (o_rel_x != '0)))
        else $error("difference flag disagrees with recorded positions");

endmodule

bind voxel_max_difference_finder_unit vmdf_checker u_vmdf_checker (.*);
